// ===== design/cpl_pkg.sv =====
// Shared types, constants and helper functions for the clipped pattern line rasterizer.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package cpl_pkg;

	localparam int MAX_DIM    = 2048;
	localparam int MAX_COLORS = 4;
	localparam int NUM_PASSES = 5;
	localparam int NUM_COLOR_REGS = 4;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_NUM_COLORS   = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_COLOR_ZERO   = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_COLOR_ONE    = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_COLOR_TWO    = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_COLOR_THREE  = 3'd6;

	localparam logic CMD_TICK  = 1'b0;
	localparam logic CMD_START = 1'b1;

	typedef logic signed [12:0] in_coord_t;
	typedef logic signed [13:0] coord_t;
	typedef logic signed [14:0] err_t;
	typedef logic        [13:0] delta_t;
	typedef logic        [11:0] dim_t;
	typedef logic        [15:0] color_t;
	typedef logic        [10:0] pix_t;
	typedef logic        [2:0]  pass_t;
	typedef logic        [2:0]  ncolor_t;

	typedef enum logic [1:0] {
		MODE_VERT = 2'd0,
		MODE_HORZ = 2'd1,
		MODE_XMAJ = 2'd2,
		MODE_YMAJ = 2'd3
	} step_mode_t;

	typedef struct packed {
		logic      cmd;
		in_coord_t start_x;
		in_coord_t start_y;
		in_coord_t end_x;
		in_coord_t end_y;
		logic      fat;
	} req_t;

	typedef struct packed {
		logic   pixel_valid;
		pix_t   pixel_x;
		pix_t   pixel_y;
		color_t pixel_color;
		logic   line_done;
		logic   busy_res;
	} res_t;

	typedef struct packed {
		dim_t    frame_width;
		dim_t    frame_height;
		ncolor_t num_colors;
		logic [NUM_COLOR_REGS-1:0][15:0] colors;
	} cfg_t;

	typedef struct packed {
		in_coord_t x1;
		in_coord_t y1;
		in_coord_t x2;
		in_coord_t y2;
	} points_t;

	typedef struct packed {
		step_mode_t mode;
		coord_t     cur_x;
		coord_t     cur_y;
		coord_t     stop;
		err_t       err;
		delta_t     dmaj;
		delta_t     dmin;
		logic       minor_dir;
		logic       has_steps;
	} pass_setup_t;

	function automatic logic signed [1:0] pass_dx(input pass_t p);
		case (p)
			3'd1: return 2'sb01;
			3'd3: return 2'sb11;
			default: return 2'sb00;
		endcase
	endfunction

	function automatic logic signed [1:0] pass_dy(input pass_t p);
		case (p)
			3'd2: return 2'sb01;
			3'd4: return 2'sb11;
			default: return 2'sb00;
		endcase
	endfunction

	function automatic dim_t eff_dim(input dim_t d);
		if (13'(d) > 13'(MAX_DIM)) return dim_t'(MAX_DIM);
		return d;
	endfunction

	function automatic ncolor_t eff_colors(input ncolor_t n);
		logic [3:0] e;
		e = {1'b0, n};
		if (n == 3'd0) e = 4'd1;
		if (e > 4'(MAX_COLORS)) e = 4'(MAX_COLORS);
		if (e > 4'd4) e = 4'd4;
		return e[2:0];
	endfunction

	function automatic logic pass_has_steps(input step_mode_t m, input coord_t cx,
	                                        input coord_t cy, input coord_t stop);
		if (m == MODE_HORZ || m == MODE_XMAJ) return cx < stop;
		return cy < stop;
	endfunction

endpackage

`default_nettype wire

// ===== design/clipped_pattern_line_rasterizer.sv =====
// Top level: configuration registers, request input register, result output register.
// Depends on cpl_pkg and cpl_line_core.
//
//   channel   signals                                    handshake
//   request   cmd start_x start_y end_x end_y fat        req_valid / req_stall
//   result    pixel_valid pixel_x pixel_y pixel_color    rsp_valid / rsp_stall
//             line_done busy_res
//   config    cfg_index cfg_data                         cfg_we
//
// One request per clock while the result is not stalled; a request passes the input register,
// then the step and pass-seek logic into the result register.
// One tick advances one pixel step; a start takes one request.
// Reset clears the handshake and the running, fat and pass state, and loads the register defaults.
// A stalled result holds; one more request is taken into the input register meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module clipped_pattern_line_rasterizer import cpl_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   req_valid,
	output logic                   req_stall,
	input  logic                   cmd,
	input  in_coord_t              start_x,
	input  in_coord_t              start_y,
	input  in_coord_t              end_x,
	input  in_coord_t              end_y,
	input  logic                   fat,
	output logic                   rsp_valid,
	input  logic                   rsp_stall,
	output logic                   pixel_valid,
	output pix_t                   pixel_x,
	output pix_t                   pixel_y,
	output color_t                 pixel_color,
	output logic                   line_done,
	output logic                   busy_res
);

	cfg_t cfg_q;
	req_t req_s1;
	logic valid_s1;
	res_t res_s2, core_res;
	logic valid_s2;
	logic advance, fire, take, running;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width  <= 12'd640;
			cfg_q.frame_height <= 12'd480;
			cfg_q.num_colors   <= 3'd1;
			cfg_q.colors       <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  cfg_q.frame_width  <= cfg_data[11:0];
				REG_FRAME_HEIGHT: cfg_q.frame_height <= cfg_data[11:0];
				REG_NUM_COLORS:   cfg_q.num_colors   <= cfg_data[2:0];
				REG_COLOR_ZERO:   cfg_q.colors[0]    <= cfg_data;
				REG_COLOR_ONE:    cfg_q.colors[1]    <= cfg_data;
				REG_COLOR_TWO:    cfg_q.colors[2]    <= cfg_data;
				REG_COLOR_THREE:  cfg_q.colors[3]    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign advance   = !valid_s2 || !rsp_stall;
	assign fire      = valid_s1 && advance;
	assign req_stall = valid_s1 && !advance;
	assign take      = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take) valid_s1 <= 1'b1;
			else if (fire) valid_s1 <= 1'b0;
			if (fire) valid_s2 <= 1'b1;
			else if (!rsp_stall) valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			req_s1 <= '{cmd: cmd, start_x: start_x, start_y: start_y,
			            end_x: end_x, end_y: end_y, fat: fat};
		if (fire) res_s2 <= core_res;
	end

	cpl_line_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.req    (req_s1),
		.cfg    (cfg_q),
		.res    (core_res),
		.running(running)
	);

	assign rsp_valid   = valid_s2;
	assign pixel_valid = res_s2.pixel_valid;
	assign pixel_x     = res_s2.pixel_x;
	assign pixel_y     = res_s2.pixel_y;
	assign pixel_color = res_s2.pixel_color;
	assign line_done   = res_s2.line_done;
	assign busy_res    = res_s2.busy_res;

`ifndef SYNTHESIS
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(line_done && busy_res))
		else $error("line_done and busy_res both set");

	a_blank_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !pixel_valid) |-> (pixel_x == '0 && pixel_y == '0 && pixel_color == '0))
		else $error("pixel fields not cleared without a write");

	a_idle_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && req_s1.cmd == CMD_TICK && !running) |=>
		(rsp_valid && !pixel_valid && !line_done && !busy_res))
		else $error("idle tick produced a non-empty result");

	a_start_no_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && req_s1.cmd == CMD_START) |=> (rsp_valid && !pixel_valid))
		else $error("start request produced a pixel write");
`endif

endmodule

`default_nettype wire

// ===== design/cpl_pass_setup.sv =====
// Setup of one drawing pass: offset endpoints, clamp or orient, derive error-term deltas.
// Depends on cpl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cpl_pass_setup import cpl_pkg::*; #(
	parameter int PASS = 0
) (
	input  points_t     pts,
	input  dim_t        w,
	input  dim_t        h,
	output pass_setup_t setup
);

	logic signed [1:0] ox, oy;
	coord_t x1, y1, x2, y2;
	coord_t wc, hc, lo, hi;
	logic signed [14:0] ddx, ddy;
	delta_t ax, ay;
	logic xmaj, swap;
	coord_t ax1, ay1, bx, by;

	assign ox = pass_dx(3'(PASS));
	assign oy = pass_dy(3'(PASS));
	assign x1 = coord_t'(pts.x1) + coord_t'(ox);
	assign y1 = coord_t'(pts.y1) + coord_t'(oy);
	assign x2 = coord_t'(pts.x2) + coord_t'(ox);
	assign y2 = coord_t'(pts.y2) + coord_t'(oy);
	assign wc = $signed({2'b00, w});
	assign hc = $signed({2'b00, h});

	assign ddx = 15'(x2) - 15'(x1);
	assign ddy = 15'(y2) - 15'(y1);
	assign ax  = (ddx < 0) ? 14'(-ddx) : 14'(ddx);
	assign ay  = (ddy < 0) ? 14'(-ddy) : 14'(ddy);
	assign xmaj = ax > ay;
	assign swap = xmaj ? (ddx < 0) : (ddy < 0);
	assign ax1 = swap ? x2 : x1;
	assign ay1 = swap ? y2 : y1;
	assign bx  = swap ? x1 : x2;
	assign by  = swap ? y1 : y2;

	always_comb begin
		setup = '0;
		lo = '0;
		hi = '0;
		if (x1 == x2) begin
			lo = (y1 > y2) ? y2 : y1;
			hi = (y1 > y2) ? y1 : y2;
			if (lo < 0) lo = '0;
			if (hi >= hc) hi = hc - 14'sd1;
			setup.mode  = MODE_VERT;
			setup.cur_x = x1;
			setup.cur_y = lo;
			setup.stop  = (x1 < 0 || x1 >= wc) ? lo : hi;
		end else if (y1 == y2) begin
			lo = (x1 > x2) ? x2 : x1;
			hi = (x1 > x2) ? x1 : x2;
			if (lo < 0) lo = '0;
			if (hi >= wc) hi = wc - 14'sd1;
			setup.mode  = MODE_HORZ;
			setup.cur_x = lo;
			setup.cur_y = y1;
			setup.stop  = (y1 < 0 || y1 >= hc) ? lo : hi;
		end else begin
			setup.cur_x = ax1;
			setup.cur_y = ay1;
			if (xmaj) begin
				setup.mode      = MODE_XMAJ;
				setup.minor_dir = !(by > ay1);
				setup.dmaj      = ax;
				setup.dmin      = ay;
				setup.stop      = bx;
			end else begin
				setup.mode      = MODE_YMAJ;
				setup.minor_dir = !(bx > ax1);
				setup.dmaj      = ay;
				setup.dmin      = ax;
				setup.stop      = by;
			end
			setup.err = -$signed({2'b00, setup.dmaj[13:1]});
		end
		setup.has_steps = pass_has_steps(setup.mode, setup.cur_x, setup.cur_y, setup.stop);
	end

endmodule

`default_nettype wire

// ===== design/cpl_line_core.sv =====
// Line state and combinational step logic: pixel clip, dash pattern, error-term walk, pass seek.
// Depends on cpl_pkg and cpl_pass_setup.
`timescale 1ns / 1ps
`default_nettype none

module cpl_line_core import cpl_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic fire,
	input  req_t req,
	input  cfg_t cfg,
	output res_t res,
	output logic running
);

	logic       running_q, fat_q;
	pass_t      pass_q;
	points_t    orig_q;
	step_mode_t mode_q;
	coord_t     cur_x_q, cur_y_q, stop_q;
	err_t       err_q;
	delta_t     dmaj_q, dmin_q;
	logic       dir_q;
	logic [1:0] dash_q, cidx_q;

	logic       n_running, n_fat;
	pass_t      n_pass;
	points_t    n_orig;
	step_mode_t n_mode;
	coord_t     n_cur_x, n_cur_y, n_stop;
	err_t       n_err;
	delta_t     n_dmaj, n_dmin;
	logic       n_dir;
	logic [1:0] n_dash, n_cidx;

	dim_t        w, h;
	ncolor_t     ncol;
	coord_t      wc, hc;
	points_t     src_pts;
	pass_setup_t setups [NUM_PASSES];
	pass_t       first, last, sel;
	logic        found, in_frame;
	logic signed [15:0] e1;
	coord_t      inc;

	assign w    = eff_dim(cfg.frame_width);
	assign h    = eff_dim(cfg.frame_height);
	assign ncol = eff_colors(cfg.num_colors);
	assign wc   = $signed({2'b00, w});
	assign hc   = $signed({2'b00, h});

	assign src_pts = (req.cmd == CMD_START) ?
		points_t'{x1: req.start_x, y1: req.start_y, x2: req.end_x, y2: req.end_y} : orig_q;

	for (genvar g = 0; g < NUM_PASSES; g++) begin : g_pass
		cpl_pass_setup #(.PASS(g)) u_setup (
			.pts  (src_pts),
			.w    (w),
			.h    (h),
			.setup(setups[g])
		);
	end

	assign first = (req.cmd == CMD_START) ? 3'd0 : pass_q + 3'd1;
	assign last  = ((req.cmd == CMD_START) ? req.fat : fat_q) ? 3'(NUM_PASSES - 1) : 3'd0;

	always_comb begin
		found = 1'b0;
		sel   = '0;
		for (int p = NUM_PASSES - 1; p >= 0; p--) begin
			if (3'(p) >= first && 3'(p) <= last && setups[p].has_steps) begin
				found = 1'b1;
				sel   = 3'(p);
			end
		end
	end

	assign in_frame = cur_x_q >= 0 && cur_x_q < wc && cur_y_q >= 0 && cur_y_q < hc;
	assign e1  = 16'(err_q) + $signed({2'b00, dmin_q});
	assign inc = dir_q ? -14'sd1 : 14'sd1;

	always_comb begin
		n_running = running_q;
		n_fat     = fat_q;
		n_pass    = pass_q;
		n_orig    = orig_q;
		n_mode    = mode_q;
		n_cur_x   = cur_x_q;
		n_cur_y   = cur_y_q;
		n_stop    = stop_q;
		n_err     = err_q;
		n_dmaj    = dmaj_q;
		n_dmin    = dmin_q;
		n_dir     = dir_q;
		n_dash    = dash_q;
		n_cidx    = cidx_q;
		res       = '0;
		if (req.cmd == CMD_START) begin
			n_orig    = src_pts;
			n_fat     = req.fat;
			n_running = found;
			res.line_done = !found;
		end else if (running_q) begin
			if (in_frame) begin
				res.pixel_valid = 1'b1;
				res.pixel_x     = cur_x_q[10:0];
				res.pixel_y     = cur_y_q[10:0];
				res.pixel_color = cfg.colors[cidx_q];
			end
			n_dash = dash_q + 2'd1;
			if (n_dash == 2'd0)
				n_cidx = ({1'b0, cidx_q} + 3'd1 >= ncol) ? 2'd0 : cidx_q + 2'd1;
			case (mode_q)
				MODE_VERT: n_cur_y = cur_y_q + 14'sd1;
				MODE_HORZ: n_cur_x = cur_x_q + 14'sd1;
				MODE_XMAJ, MODE_YMAJ: begin
					n_err = 15'(e1);
					if (e1 >= 0) begin
						n_err = 15'(e1 - $signed({2'b00, dmaj_q}));
						if (mode_q == MODE_XMAJ) n_cur_y = cur_y_q + inc;
						else n_cur_x = cur_x_q + inc;
					end
					if (mode_q == MODE_XMAJ) n_cur_x = cur_x_q + 14'sd1;
					else n_cur_y = cur_y_q + 14'sd1;
				end
				default: ;
			endcase
			if (!pass_has_steps(mode_q, n_cur_x, n_cur_y, stop_q)) begin
				n_running = found;
				res.line_done = !found;
			end
		end
		if ((req.cmd == CMD_START || (running_q && res.line_done == 1'b0 &&
		     !pass_has_steps(mode_q, n_cur_x, n_cur_y, stop_q))) && found) begin
			n_pass  = sel;
			n_mode  = setups[sel].mode;
			n_cur_x = setups[sel].cur_x;
			n_cur_y = setups[sel].cur_y;
			n_stop  = setups[sel].stop;
			n_err   = setups[sel].err;
			n_dmaj  = setups[sel].dmaj;
			n_dmin  = setups[sel].dmin;
			n_dir   = setups[sel].minor_dir;
			n_dash  = 2'd0;
			n_cidx  = 2'd0;
		end
		res.busy_res = n_running;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			fat_q     <= 1'b0;
			pass_q    <= '0;
		end else if (fire) begin
			running_q <= n_running;
			fat_q     <= n_fat;
			pass_q    <= n_pass;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			orig_q  <= n_orig;
			mode_q  <= n_mode;
			cur_x_q <= n_cur_x;
			cur_y_q <= n_cur_y;
			stop_q  <= n_stop;
			err_q   <= n_err;
			dmaj_q  <= n_dmaj;
			dmin_q  <= n_dmin;
			dir_q   <= n_dir;
			dash_q  <= n_dash;
			cidx_q  <= n_cidx;
		end
	end

	assign running = running_q;

endmodule

`default_nettype wire

// ===== verif/tb_clipped_pattern_line_rasterizer.sv =====
// Self-checking testbench for clipped_pattern_line_rasterizer: directed lines, then random lines.
// A built-in line stepper predicts every result; depends on cpl_pkg and the design top level.
`timescale 1ns / 1ps

module tb_clipped_pattern_line_rasterizer;
	import cpl_pkg::*;

	localparam int RAND_ITEMS = 1400;
	localparam int QUIET_LIMIT = 2000;
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic req_valid;
	logic req_stall;
	logic cmd;
	in_coord_t start_x;
	in_coord_t start_y;
	in_coord_t end_x;
	in_coord_t end_y;
	logic fat;
	logic rsp_valid;
	logic rsp_stall;
	logic pixel_valid;
	pix_t pixel_x;
	pix_t pixel_y;
	color_t pixel_color;
	logic line_done;
	logic busy_res;

	clipped_pattern_line_rasterizer dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.cmd(cmd),
		.start_x(start_x),
		.start_y(start_y),
		.end_x(end_x),
		.end_y(end_y),
		.fat(fat),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.pixel_valid(pixel_valid),
		.pixel_x(pixel_x),
		.pixel_y(pixel_y),
		.pixel_color(pixel_color),
		.line_done(line_done),
		.busy_res(busy_res)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	int errors = 0;
	res_t pixel_q[$];
	bit gap_en = 1'b0;
	bit stall_en = 1'b0;
	int stall_left = 0;
	int eff_w = 640;
	int eff_h = 480;

	// line stepper copy of the block
	int cfg_w, cfg_h, cfg_ncol;
	logic [15:0] cfg_pal[4];
	bit ln_run, ln_fat, ln_minor_neg;
	step_mode_t ln_mode;
	int ln_pass, ln_dash, ln_cidx;
	int ln_pts[4];
	int ln_cx, ln_cy, ln_stop, ln_err, ln_dmaj, ln_dmin;

	function automatic int iabs(int a);
		return (a < 0) ? -a : a;
	endfunction

	function automatic int dim_limit(int d);
		return (d > MAX_DIM) ? MAX_DIM : d;
	endfunction

	function automatic int palette_len();
		int n;
		n = cfg_ncol;
		if (n == 0) n = 1;
		if (n > MAX_COLORS) n = MAX_COLORS;
		if (n > 4) n = 4;
		return n;
	endfunction

	function automatic void stepper_reset();
		cfg_w = 640;
		cfg_h = 480;
		cfg_ncol = 1;
		for (int i = 0; i < 4; i++) begin
			cfg_pal[i] = '0;
			ln_pts[i] = 0;
		end
		ln_run = 1'b0;
		ln_fat = 1'b0;
		ln_minor_neg = 1'b0;
		ln_mode = MODE_VERT;
		ln_pass = 0;
		ln_dash = 0;
		ln_cidx = 0;
		ln_cx = 0;
		ln_cy = 0;
		ln_stop = 0;
		ln_err = 0;
		ln_dmaj = 0;
		ln_dmin = 0;
	endfunction

	function automatic void apply_reg(logic [CFG_INDEX_W-1:0] idx, logic [15:0] val);
		case (idx)
			REG_FRAME_WIDTH: cfg_w = val[11:0];
			REG_FRAME_HEIGHT: cfg_h = val[11:0];
			REG_NUM_COLORS: cfg_ncol = val[2:0];
			REG_COLOR_ZERO: cfg_pal[0] = val;
			REG_COLOR_ONE: cfg_pal[1] = val;
			REG_COLOR_TWO: cfg_pal[2] = val;
			REG_COLOR_THREE: cfg_pal[3] = val;
			default: ;
		endcase
	endfunction

	function automatic bit pass_live();
		if (ln_mode == MODE_HORZ || ln_mode == MODE_XMAJ) return ln_cx < ln_stop;
		return ln_cy < ln_stop;
	endfunction

	function automatic void load_pass(int p);
		int x1, y1, x2, y2, w, h, t, dx, dy, ax, ay;
		bit xmaj;
		x1 = ln_pts[0] + ((p == 1) ? 1 : (p == 3) ? -1 : 0);
		y1 = ln_pts[1] + ((p == 2) ? 1 : (p == 4) ? -1 : 0);
		x2 = ln_pts[2] + ((p == 1) ? 1 : (p == 3) ? -1 : 0);
		y2 = ln_pts[3] + ((p == 2) ? 1 : (p == 4) ? -1 : 0);
		w = dim_limit(cfg_w);
		h = dim_limit(cfg_h);
		ln_dash = 0;
		ln_cidx = 0;
		ln_err = 0;
		ln_dmaj = 0;
		ln_dmin = 0;
		ln_minor_neg = 1'b0;
		if (x1 == x2) begin
			ln_mode = MODE_VERT;
			if (y1 > y2) begin
				t = y1; y1 = y2; y2 = t;
			end
			if (y1 < 0) y1 = 0;
			if (y2 >= h) y2 = h - 1;
			ln_cx = x1;
			ln_cy = y1;
			ln_stop = (x1 < 0 || x1 >= w) ? y1 : y2;
		end else if (y1 == y2) begin
			ln_mode = MODE_HORZ;
			if (x1 > x2) begin
				t = x1; x1 = x2; x2 = t;
			end
			if (x1 < 0) x1 = 0;
			if (x2 >= w) x2 = w - 1;
			ln_cx = x1;
			ln_cy = y1;
			ln_stop = (y1 < 0 || y1 >= h) ? x1 : x2;
		end else begin
			dx = x2 - x1;
			dy = y2 - y1;
			ax = iabs(dx);
			ay = iabs(dy);
			xmaj = ax > ay;
			if ((xmaj && dx < 0) || (!xmaj && dy < 0)) begin
				t = x1; x1 = x2; x2 = t;
				t = y1; y1 = y2; y2 = t;
			end
			ln_cx = x1;
			ln_cy = y1;
			if (xmaj) begin
				ln_mode = MODE_XMAJ;
				ln_minor_neg = !(y2 > y1);
				ln_dmaj = ax;
				ln_dmin = ay;
				ln_stop = x2;
			end else begin
				ln_mode = MODE_YMAJ;
				ln_minor_neg = !(x2 > x1);
				ln_dmaj = ay;
				ln_dmin = ax;
				ln_stop = y2;
			end
			ln_err = -(ln_dmaj >> 1);
		end
	endfunction

	function automatic void seek_pass(int p);
		int last, q;
		last = ln_fat ? 4 : 0;
		for (q = p; q <= last; q++) begin
			load_pass(q);
			if (pass_live()) begin
				ln_pass = q;
				ln_run = 1'b1;
				return;
			end
		end
		ln_run = 1'b0;
	endfunction

	function automatic res_t rasterize_step(logic c, int sx, int sy, int ex, int ey, logic f);
		res_t r;
		int w, h, inc;
		r = '0;
		if (c == CMD_START) begin
			ln_pts[0] = sx;
			ln_pts[1] = sy;
			ln_pts[2] = ex;
			ln_pts[3] = ey;
			ln_fat = f;
			seek_pass(0);
			r.line_done = !ln_run;
		end else if (ln_run) begin
			w = dim_limit(cfg_w);
			h = dim_limit(cfg_h);
			if (ln_cx >= 0 && ln_cx < w && ln_cy >= 0 && ln_cy < h) begin
				r.pixel_valid = 1'b1;
				r.pixel_x = pix_t'(ln_cx);
				r.pixel_y = pix_t'(ln_cy);
				r.pixel_color = cfg_pal[ln_cidx & 3];
			end
			ln_dash = (ln_dash + 1) & 3;
			if (ln_dash == 0)
				ln_cidx = (ln_cidx + 1 >= palette_len()) ? 0 : ((ln_cidx + 1) & 3);
			case (ln_mode)
				MODE_VERT: ln_cy++;
				MODE_HORZ: ln_cx++;
				default: begin
					inc = ln_minor_neg ? -1 : 1;
					ln_err += ln_dmin;
					if (ln_err >= 0) begin
						if (ln_mode == MODE_XMAJ) ln_cy += inc;
						else ln_cx += inc;
						ln_err -= ln_dmaj;
					end
					if (ln_mode == MODE_XMAJ) ln_cx++;
					else ln_cy++;
				end
			endcase
			if (!pass_live()) begin
				seek_pass(ln_pass + 1);
				if (!ln_run) r.line_done = 1'b1;
			end
		end
		r.busy_res = ln_run;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		res_t want;
		if (arst_n) begin
			if (cfg_we) apply_reg(cfg_index, cfg_data);
			if (req_valid && !req_stall)
				pixel_q.push_back(rasterize_step(cmd, start_x, start_y, end_x, end_y, fat));
			if (rsp_valid && !rsp_stall) begin
				if (pixel_q.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual valid=%0b x=%0d y=%0d",
						$time, pixel_valid, pixel_x, pixel_y);
					errors++;
				end else begin
					want = pixel_q.pop_front();
					check_field("pixel_valid", want.pixel_valid, pixel_valid);
					check_field("pixel_x", want.pixel_x, pixel_x);
					check_field("pixel_y", want.pixel_y, pixel_y);
					check_field("pixel_color", want.pixel_color, pixel_color);
					check_field("line_done", want.line_done, line_done);
					check_field("busy_res", want.busy_res, busy_res);
				end
			end
		end
	end

	function automatic int idle_len();
		return ($urandom_range(0, 15) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 3);
	endfunction

	function automatic int rand13();
		return $urandom_range(0, 8191) - 4096;
	endfunction

	function automatic int pick_coord(int lim);
		case ($urandom_range(0, 2))
			0: return $urandom_range(0, 8) - 4;
			1: return lim + $urandom_range(0, 8) - 4;
			default: return $urandom_range(0, lim + 8) - 4;
		endcase
	endfunction

	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			rsp_stall <= 1'b1;
		end else if (stall_en && $urandom_range(0, 3) == 0) begin
			stall_left <= idle_len() - 1;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	task automatic send_req(input logic c, input int sx, input int sy, input int ex, input int ey,
	                        input logic f);
		int gap;
		gap = (gap_en && $urandom_range(0, 2) == 0) ? idle_len() : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		cmd <= c;
		start_x <= in_coord_t'(sx);
		start_y <= in_coord_t'(sy);
		end_x <= in_coord_t'(ex);
		end_y <= in_coord_t'(ey);
		fat <= f;
		do @(posedge clk); while (req_stall);
	endtask

	task automatic tick_n(input int n);
		repeat (n) send_req(CMD_TICK, rand13(), rand13(), rand13(), rand13(),
		                    1'($urandom_range(0, 1)));
	endtask

	task automatic draw(input int sx, input int sy, input int ex, input int ey, input logic f,
	                    input int ticks);
		send_req(CMD_START, sx, sy, ex, ey, f);
		tick_n(ticks);
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		do @(posedge clk); while (pixel_q.size() != 0);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == REG_FRAME_WIDTH) eff_w = dim_limit(val[11:0]);
		if (idx == REG_FRAME_HEIGHT) eff_h = dim_limit(val[11:0]);
	endtask

	task automatic load_config(input logic [15:0] w, input logic [15:0] h, input logic [15:0] n,
	                           input logic [15:0] c0, input logic [15:0] c1,
	                           input logic [15:0] c2, input logic [15:0] c3);
		wait_drained();
		write_reg(REG_FRAME_WIDTH, w);
		write_reg(REG_FRAME_HEIGHT, h);
		write_reg(REG_NUM_COLORS, n);
		write_reg(REG_COLOR_ZERO, c0);
		write_reg(REG_COLOR_ONE, c1);
		write_reg(REG_COLOR_TWO, c2);
		write_reg(REG_COLOR_THREE, c3);
	endtask

	task automatic random_config();
		int w, h;
		case ($urandom_range(0, 9))
			0: begin
				w = MAX_DIM;
				h = MAX_DIM;
			end
			1: begin
				w = $urandom_range(MAX_DIM, 4095);
				h = $urandom_range(MAX_DIM, 4095);
			end
			2: begin
				w = $urandom_range(0, 2);
				h = $urandom_range(0, 40);
			end
			default: begin
				w = $urandom_range(1, 40);
				h = $urandom_range(1, 40);
			end
		endcase
		load_config({4'($urandom), 12'(w)}, {4'($urandom), 12'(h)}, 16'($urandom),
			16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
		if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, 16'($urandom));
		gap_en = $urandom_range(0, 3) != 0;
		stall_en = $urandom_range(0, 3) != 0;
	endtask

	task automatic test_idle_and_defaults();
		tick_n(1);
		draw(636, 2, 642, 2, 1'b0, 4);
	endtask

	task automatic test_frame_extremes();
		load_config(16'h0FFF, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'hAAAA, 16'h5555);
		draw(3, 0, 3, 4, 1'b0, 1);
	endtask

	task automatic test_pattern_wrap();
		load_config(16'(MAX_DIM), 16'(MAX_DIM), 16'h0007, 16'h1111, 16'h2222, 16'h3333,
			16'h4444);
		draw(2040, 2046, 2049, 2050, 1'b0, 9);
	endtask

	task automatic test_fat_and_abandon();
		draw(10, 10, 12, 11, 1'b1, 10);
		draw(-4096, -4096, 4095, 4095, 1'b1, 2);
		draw(4095, -4096, -4096, 4095, 1'b0, 1);
		draw(5, 5, 5, 5, 1'b0, 1);
	endtask

	task automatic test_random_lines();
		int made, next_cfg, sx, sy, ex, ey, est, ticks, k;
		logic f;
		bit paused;
		made = 0;
		next_cfg = 0;
		paused = 1'b0;
		while (made < RAND_ITEMS) begin
			if (made >= next_cfg) begin
				random_config();
				next_cfg = made + 150 + $urandom_range(0, 100);
			end
			if (!paused && made >= RAND_ITEMS / 2) begin
				wait_drained();
				paused = 1'b1;
			end
			k = $urandom_range(0, 19);
			sx = pick_coord(eff_w);
			sy = pick_coord(eff_h);
			ex = sx + $urandom_range(0, 24) - 12;
			ey = sy + $urandom_range(0, 24) - 12;
			if (k < 3) ex = sx;
			else if (k < 6) ey = sy;
			else if (k == 6) begin
				ex = sx;
				ey = sy;
			end
			f = $urandom_range(0, 2) == 0;
			est = ((iabs(ex - sx) > iabs(ey - sy)) ? iabs(ex - sx) : iabs(ey - sy)) * (f ? 5 : 1) + 1;
			if (k == 19) begin
				sx = rand13();
				sy = rand13();
				ex = rand13();
				ey = rand13();
				ticks = $urandom_range(0, 6);
			end else if ($urandom_range(0, 7) == 0) begin
				ticks = $urandom_range(0, est);
			end else begin
				ticks = est + $urandom_range(0, 2);
			end
			if (ticks > 2 && $urandom_range(0, 15) == 0) begin
				draw(sx, sy, ex, ey, f, ticks / 2);
				wait_drained();
				write_reg(REG_NUM_COLORS, 16'($urandom));
				tick_n(ticks - ticks / 2);
			end else begin
				draw(sx, sy, ex, ey, f, ticks);
			end
			made += 1 + ticks;
		end
	endtask

	initial begin
		stepper_reset();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		req_valid = 1'b0;
		cmd = CMD_TICK;
		start_x = '0;
		start_y = '0;
		end_x = '0;
		end_y = '0;
		fat = 1'b0;
		rsp_stall = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_and_defaults();
		test_frame_extremes();
		test_pattern_wrap();
		test_fat_and_abandon();
		test_random_lines();
		wait_drained();
		repeat (4) @(posedge clk);
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
			else quiet++;
		end
		$display("Some tests failed");
		$finish;
	end

endmodule
